// ===== src/mstrk_pkg.sv =====
`default_nettype none

package mstrk_pkg;

  // fixed field widths of the channels
  localparam int unsigned FIELD_BITS  = 32;
  localparam int unsigned RADIUS_BITS = 31;
  localparam int unsigned OUT_BITS    = 33;

  // all ones stands for an infinite change; finite results stop one below
  localparam logic [OUT_BITS-1:0] CHANGE_INFINITE = {OUT_BITS{1'b1}};
  localparam logic [OUT_BITS-1:0] CHANGE_TOP      = {{(OUT_BITS-1){1'b1}}, 1'b0};

  typedef enum logic [1:0] {
    CMD_RECORD         = 2'd0,
    CMD_COMPARE        = 2'd1,
    CMD_RECORD_CHANGED = 2'd2
  } cmd_t;

endpackage

`default_nettype wire

// ===== src/mstrk_if.sv =====
`default_nettype none

// input channel: one sphere per transfer
interface mstrk_in_if;
  logic                                       valid;
  logic                                       ready;
  logic [1:0]                                 command;
  logic signed [mstrk_pkg::FIELD_BITS-1:0]    center_x;
  logic signed [mstrk_pkg::FIELD_BITS-1:0]    center_y;
  logic signed [mstrk_pkg::FIELD_BITS-1:0]    center_z;
  logic [mstrk_pkg::RADIUS_BITS-1:0]          sphere_radius;
  logic                                       last_of_set;

  modport source (
    output valid, command, center_x, center_y, center_z, sphere_radius, last_of_set,
    input  ready
  );
  modport sink (
    input  valid, command, center_x, center_y, center_z, sphere_radius, last_of_set,
    output ready
  );
endinterface

// result channel: one maximum change per transfer
interface mstrk_out_if;
  logic                             valid;
  logic                             ready;
  logic [mstrk_pkg::OUT_BITS-1:0]   max_change;

  modport source (output valid, max_change, input ready);
  modport sink   (input valid, max_change, output ready);
endinterface

`default_nettype wire

// ===== src/mstrk_change.sv =====
`default_nettype none

// Per-item change: max axis distance to the snapshot, plus radius distance
// when enabled, saturated below the infinite code.
module mstrk_change #(
  parameter int COORD_BITS = 32
) (
  input  wire logic signed [COORD_BITS-1:0]             cur_x,
  input  wire logic signed [COORD_BITS-1:0]             cur_y,
  input  wire logic signed [COORD_BITS-1:0]             cur_z,
  input  wire logic [mstrk_pkg::RADIUS_BITS-1:0]        cur_radius,
  input  wire logic signed [COORD_BITS-1:0]             snap_x,
  input  wire logic signed [COORD_BITS-1:0]             snap_y,
  input  wire logic signed [COORD_BITS-1:0]             snap_z,
  input  wire logic [mstrk_pkg::RADIUS_BITS-1:0]        snap_radius,
  input  wire logic                                     use_radius,
  output logic [mstrk_pkg::OUT_BITS-1:0]                change
);

  localparam int RB = mstrk_pkg::RADIUS_BITS;
  localparam int SW = ((COORD_BITS > RB) ? COORD_BITS : RB) + 1;
  localparam int CW = (SW > mstrk_pkg::OUT_BITS) ? SW : mstrk_pkg::OUT_BITS;

  logic signed [COORD_BITS:0] dx, dy, dz;
  logic [COORD_BITS-1:0]      ax, ay, az, axis_max;
  logic signed [RB:0]         dr;
  logic [RB-1:0]              ar;
  logic [SW-1:0]              sum;
  logic [CW-1:0]              sum_ext;

  always_comb begin
    dx = {cur_x[COORD_BITS-1], cur_x} - {snap_x[COORD_BITS-1], snap_x};
    dy = {cur_y[COORD_BITS-1], cur_y} - {snap_y[COORD_BITS-1], snap_y};
    dz = {cur_z[COORD_BITS-1], cur_z} - {snap_z[COORD_BITS-1], snap_z};
    ax = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    ay = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
    az = dz[COORD_BITS] ? COORD_BITS'(-dz) : COORD_BITS'(dz);

    axis_max = (ay > ax) ? ay : ax;
    if (az > axis_max) begin
      axis_max = az;
    end

    dr = $signed({1'b0, cur_radius}) - $signed({1'b0, snap_radius});
    ar = dr[RB] ? RB'(-dr) : RB'(dr);

    sum = SW'(axis_max);
    if (use_radius) begin
      sum = sum + SW'(ar);
    end

    sum_ext = CW'(sum);
    if (sum_ext > CW'(mstrk_pkg::CHANGE_TOP)) begin
      change = mstrk_pkg::CHANGE_TOP;
    end else begin
      change = mstrk_pkg::OUT_BITS'(sum_ext);
    end
  end

endmodule

`default_nettype wire

// ===== src/max_sphere_displacement_tracker_core.sv =====
// A pass's result follows its last item through stage 1 into the out_chan output register.
// Throughput: one item per cycle unless stalled; items read a slot, records write it.
// Results only stall the input when the output register is full and not being taken.
// Reset (rst_n low, synchronous): clears position, running max, use_radius and valid flags.
// Snapshot stores are not cleared; slots hold garbage until recorded.
`default_nettype none

module max_sphere_displacement_tracker_core #(
  parameter int MAX_ITEMS  = 1024,
  parameter int COORD_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  mstrk_in_if.sink         in_chan,
  mstrk_out_if.source      out_chan
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int RB = mstrk_pkg::RADIUS_BITS;
  localparam int OB = mstrk_pkg::OUT_BITS;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic use_radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_radius_r <= 1'b0;
    end else if (cfg_wr_en) begin
      use_radius_r <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  logic                   in_fire;
  logic                   is_record, is_compare, is_changed, is_known;
  logic [COORD_BITS-1:0]  in_x, in_y, in_z;
  logic [RB-1:0]          in_radius;

  assign in_fire = in_chan.valid && in_chan.ready;

  always_comb begin
    is_record  = 1'b0;
    is_compare = 1'b0;
    is_changed = 1'b0;
    unique case (in_chan.command)
      mstrk_pkg::CMD_RECORD:         is_record  = 1'b1;
      mstrk_pkg::CMD_COMPARE:        is_compare = 1'b1;
      mstrk_pkg::CMD_RECORD_CHANGED: is_changed = 1'b1;
      default: ; // unused code: item is dropped, nothing changes
    endcase
    is_known = is_record || is_compare || is_changed;
  end

  // coordinates live in the low COORD_BITS bits of the field
  assign in_x      = COORD_BITS'($unsigned(in_chan.center_x));
  assign in_y      = COORD_BITS'($unsigned(in_chan.center_y));
  assign in_z      = COORD_BITS'($unsigned(in_chan.center_z));
  // radius is stored and compared as zero while radii are off
  assign in_radius = use_radius_r ? in_chan.sphere_radius : '0;

  // ---------------------------------------------------------------------------
  // Position counter: advances per known item, back to slot 0 after the last
  // ---------------------------------------------------------------------------
  logic [AW-1:0] pos_r, pos_nxt;

  always_comb begin
    pos_nxt = pos_r;
    if (in_fire && is_known) begin
      if (in_chan.last_of_set || (pos_r == AW'(MAX_ITEMS - 1))) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Snapshot stores. Written and read at the transfer edge; an item never
  // records and compares at once, and a slot written on one edge is read back
  // correctly on the next, so no bypass is needed.
  // ---------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] snap_x_mem [MAX_ITEMS];
  logic signed [COORD_BITS-1:0] snap_y_mem [MAX_ITEMS];
  logic signed [COORD_BITS-1:0] snap_z_mem [MAX_ITEMS];
  logic [RB-1:0]                snap_r_mem [MAX_ITEMS];

  logic signed [COORD_BITS-1:0] rd_x_r, rd_y_r, rd_z_r;
  logic [RB-1:0]                rd_r_r;

  always_ff @(posedge clk) begin
    if (in_fire && (is_record || is_changed)) begin
      snap_x_mem[pos_r] <= in_x;
      snap_y_mem[pos_r] <= in_y;
      snap_z_mem[pos_r] <= in_z;
      snap_r_mem[pos_r] <= in_radius;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_x_r <= snap_x_mem[pos_r];
      rd_y_r <= snap_y_mem[pos_r];
      rd_z_r <= snap_z_mem[pos_r];
      rd_r_r <= snap_r_mem[pos_r];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: registered item, lined up with the snapshot read data
  // ---------------------------------------------------------------------------
  logic                         s1_valid_r;
  logic                         s1_compare_r, s1_changed_r, s1_last_r;
  logic signed [COORD_BITS-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic [RB-1:0]                s1_radius_r;
  logic                         s1_produce, s1_adv;

  // only the last item of a compare or record-after-change pass has a result
  assign s1_produce = s1_last_r && (s1_compare_r || s1_changed_r);
  assign s1_adv     = s1_valid_r && (!s1_produce || !out_chan.valid || out_chan.ready);

  assign in_chan.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= is_known;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_compare_r <= is_compare;
      s1_changed_r <= is_changed;
      s1_last_r    <= in_chan.last_of_set;
      s1_x_r       <= in_x;
      s1_y_r       <= in_y;
      s1_z_r       <= in_z;
      s1_radius_r  <= in_radius;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: change, running maximum and result register
  // ---------------------------------------------------------------------------
  logic [OB-1:0] change, new_max;
  logic [OB-1:0] run_max_r, run_max_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [OB-1:0] out_max_r, out_max_nxt;

  mstrk_change #(
    .COORD_BITS (COORD_BITS)
  ) u_change (
    .cur_x       (s1_x_r),
    .cur_y       (s1_y_r),
    .cur_z       (s1_z_r),
    .cur_radius  (s1_radius_r),
    .snap_x      (rd_x_r),
    .snap_y      (rd_y_r),
    .snap_z      (rd_z_r),
    .snap_radius (rd_r_r),
    .use_radius  (use_radius_r),
    .change      (change)
  );

  assign new_max = (change > run_max_r) ? change : run_max_r;

  always_comb begin
    run_max_nxt   = run_max_r;
    out_valid_nxt = out_valid_r;
    out_max_nxt   = out_max_r;

    if (out_chan.valid && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (s1_adv) begin
      // any pass end clears the maximum for the next pass
      if (s1_last_r) begin
        run_max_nxt = '0;
      end else if (s1_compare_r) begin
        run_max_nxt = new_max;
      end

      if (s1_produce) begin
        out_valid_nxt = 1'b1;
        out_max_nxt   = s1_compare_r ? new_max : mstrk_pkg::CHANGE_INFINITE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_max_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      run_max_r   <= run_max_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_max_r <= out_max_nxt;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.max_change = out_max_r;

endmodule

`default_nettype wire

// ===== src/mstrk_checker.sv =====
`default_nettype none

module mstrk_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [mstrk_pkg::OUT_BITS-1:0]  out_max_change
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_max_change))
    else $error("result dropped or changed while stalled");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // input only stalls behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  // an empty output register never holds off the input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input not ready with empty output");

endmodule

bind max_sphere_displacement_tracker_core mstrk_checker u_mstrk_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_max_change (out_chan.max_change)
);

`default_nettype wire
